[hw/rtl/lss_pkg.sv]
// Shared types, widths and codes for the 3x3 Cramer's rule solver.
// Depends on nothing; every other file of the block imports it.
package lss_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// A 2x2 minor needs one bit over a product, a cofactor term one more
	// input width, and the sum of three terms two more bits.
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int MINOR_W = 2 * DATA_WIDTH + 1;
	localparam int PART_W  = 2 * DATA_WIDTH + 1;
	localparam int TERM_W  = 3 * DATA_WIDTH + 1;
	localparam int DET_W   = 3 * DATA_WIDTH + 3;
	localparam int REM_W   = DET_W + DATA_WIDTH + FRAC_BITS;

	localparam int DET_LAT  = 5;
	localparam int DIV_LAT  = DATA_WIDTH + 2;
	localparam int LATENCY  = DET_LAT + DIV_LAT + 1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [MINOR_W-1:0]    minor_t;
	typedef logic signed [PART_W-1:0]     part_t;
	typedef logic signed [TERM_W-1:0]     term_t;
	typedef logic signed [DET_W-1:0]      det_t;
	typedef logic [DET_W-1:0]             mag_t;
	typedef logic [REM_W-1:0]             rem_t;
	typedef logic [DATA_WIDTH-1:0]        quo_t;

	// Row-major 3x3 matrix, element 0 is row 1 column 1.
	typedef logic [8:0][DATA_WIDTH-1:0] mat3_t;

	typedef enum logic [1:0] {
		ST_SOLVED    = 2'd0,
		ST_SINGULAR  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	typedef struct packed {
		data_t a11;
		data_t a12;
		data_t a13;
		data_t a21;
		data_t a22;
		data_t a23;
		data_t a31;
		data_t a32;
		data_t a33;
		data_t rhs1;
		data_t rhs2;
		data_t rhs3;
	} operands_t;

	typedef struct packed {
		data_t   sol_x;
		data_t   sol_y;
		data_t   sol_z;
		status_t status;
	} solution_t;

	// What one division lane hands to the merging stage.
	typedef struct packed {
		quo_t mag;
		logic neg;
		logic ovf;
	} lane_res_t;

endpackage

[hw/rtl/lss_det3.sv]
// Five-stage pipelined 3x3 determinant by cofactor expansion on row 1.
// Depends on lss_pkg.
module lss_det3 (
	input  logic          clk,
	input  lss_pkg::mat3_t mat,
	output lss_pkg::det_t  det
);
	import lss_pkg::*;

	data_t  e [9];
	prod_t  p_s1 [6];
	data_t  row_s1 [3];
	minor_t c_s2 [3];
	data_t  row_s2 [3];
	part_t  lo_s3 [3];
	part_t  hi_s3 [3];
	term_t  t_s4 [3];
	det_t   det_s5;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			e[i] = data_t'(mat[i]);
		end
	end

	// Stage 1: the six products of the three 2x2 minors.
	always_ff @(posedge clk) begin
		p_s1[0] <= e[4] * e[8];
		p_s1[1] <= e[7] * e[5];
		p_s1[2] <= e[3] * e[8];
		p_s1[3] <= e[5] * e[6];
		p_s1[4] <= e[3] * e[7];
		p_s1[5] <= e[6] * e[4];
		for (int j = 0; j < 3; j++) begin
			row_s1[j] <= e[j];
		end
	end

	// Stage 2: minors.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			c_s2[j]   <= MINOR_W'(p_s1[2*j]) - MINOR_W'(p_s1[2*j+1]);
			row_s2[j] <= row_s1[j];
		end
	end

	// Stage 3: each minor times its row-1 element, split into two partial products.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			lo_s3[j] <= $signed({1'b0, c_s2[j][DATA_WIDTH-1:0]}) * row_s2[j];
			hi_s3[j] <= $signed(c_s2[j][MINOR_W-1:DATA_WIDTH]) * row_s2[j];
		end
	end

	// Stage 4: recombine the partial products.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			t_s4[j] <= $signed({hi_s3[j], {DATA_WIDTH{1'b0}}}) + TERM_W'(lo_s3[j]);
		end
	end

	// Stage 5: alternating sum of the cofactor terms.
	always_ff @(posedge clk) begin
		det_s5 <= DET_W'(t_s4[0]) - DET_W'(t_s4[1]) + DET_W'(t_s4[2]);
	end

	assign det = det_s5;

endmodule

[hw/rtl/lss_div.sv]
// Pipelined restoring divider giving trunc(|num| * 2^FRAC_BITS / |den|),
// one quotient bit per stage, with overflow and sign flags. Depends on lss_pkg.
module lss_div (
	input  logic             clk,
	input  lss_pkg::det_t    num,
	input  lss_pkg::det_t    den,
	output lss_pkg::lane_res_t res
);
	import lss_pkg::*;

	logic neg_s1;
	mag_t n_s1;
	mag_t d_s1;
	rem_t n_ext;
	rem_t d_top;

	rem_t rem_sn [DATA_WIDTH+1];
	mag_t d_sn   [DATA_WIDTH+1];
	quo_t q_sn   [DATA_WIDTH+1];
	logic neg_sn [DATA_WIDTH+1];
	logic ovf_sn [DATA_WIDTH+1];

	// Stage 1: magnitudes and result sign.
	always_ff @(posedge clk) begin
		neg_s1 <= num[DET_W-1] ^ den[DET_W-1];
		n_s1   <= num[DET_W-1] ? mag_t'(-num) : mag_t'(num);
		d_s1   <= den[DET_W-1] ? mag_t'(-den) : mag_t'(den);
	end

	// Stage 2: scale the numerator and catch quotients of DATA_WIDTH+1 bits or more.
	assign n_ext = REM_W'({n_s1, {FRAC_BITS{1'b0}}});
	assign d_top = REM_W'(d_s1) << DATA_WIDTH;

	always_ff @(posedge clk) begin
		rem_sn[0] <= n_ext;
		d_sn[0]   <= d_s1;
		q_sn[0]   <= '0;
		neg_sn[0] <= neg_s1;
		ovf_sn[0] <= (n_ext >= d_top);
	end

	for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_bit
		localparam int B = DATA_WIDTH - 1 - g;
		rem_t sh;
		logic ge;

		assign sh = REM_W'(d_sn[g]) << B;
		assign ge = (rem_sn[g] >= sh);

		always_ff @(posedge clk) begin
			rem_sn[g+1] <= ge ? (rem_sn[g] - sh) : rem_sn[g];
			q_sn[g+1]   <= {q_sn[g][DATA_WIDTH-2:0], ge};
			d_sn[g+1]   <= d_sn[g];
			neg_sn[g+1] <= neg_sn[g];
			ovf_sn[g+1] <= ovf_sn[g];
		end
	end

	assign res.mag = q_sn[DATA_WIDTH];
	assign res.neg = neg_sn[DATA_WIDTH];
	assign res.ovf = ovf_sn[DATA_WIDTH];

endmodule

[hw/rtl/lss_merge.sv]
// Merging stage: saturates the three lane quotients, applies signs and
// forms the status code in the output register. Depends on lss_pkg.
module lss_merge (
	input  logic               clk,
	input  lss_pkg::lane_res_t lx,
	input  lss_pkg::lane_res_t ly,
	input  lss_pkg::lane_res_t lz,
	input  logic               singular,
	output lss_pkg::solution_t solution
);
	import lss_pkg::*;

	localparam data_t MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	solution_t sol_q;
	logic      sx;
	logic      sy;
	logic      sz;

	function automatic logic lane_sat(lane_res_t l);
		if (l.neg) begin
			return l.ovf | (l.mag[DATA_WIDTH-1] & (|l.mag[DATA_WIDTH-2:0]));
		end
		return l.ovf | l.mag[DATA_WIDTH-1];
	endfunction

	function automatic data_t lane_val(lane_res_t l);
		if (lane_sat(l)) begin
			return l.neg ? MIN_VAL : MAX_VAL;
		end
		return l.neg ? data_t'(-l.mag) : data_t'(l.mag);
	endfunction

	assign sx = lane_sat(lx);
	assign sy = lane_sat(ly);
	assign sz = lane_sat(lz);

	always_ff @(posedge clk) begin
		if (singular) begin
			sol_q.sol_x  <= '0;
			sol_q.sol_y  <= '0;
			sol_q.sol_z  <= '0;
			sol_q.status <= ST_SINGULAR;
		end else begin
			sol_q.sol_x  <= lane_val(lx);
			sol_q.sol_y  <= lane_val(ly);
			sol_q.sol_z  <= lane_val(lz);
			sol_q.status <= (sx | sy | sz) ? ST_SATURATED : ST_SOLVED;
		end
	end

	assign solution = sol_q;

endmodule

[hw/rtl/linear_system_3x3_solver_top.sv]
// Top level of the 3x3 Cramer's rule solver: four determinant lanes,
// three division lanes and a merging stage. Depends on lss_pkg and all lss_ modules.
// A transaction passes the determinant stages, the bit-per-stage quotient pipeline
// and the merge register between the accepting edge and the done strobe.
// Throughput is one transaction per cycle; busy stays low and the result cannot be stalled.
// Reset clears only the valid pipeline, so no strobe appears for items in flight.
module linear_system_3x3_solver_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lss_pkg::operands_t operands,
	output logic               done,
	output lss_pkg::solution_t solution
);
	import lss_pkg::*;

	// Matrices for the main determinant and the three with one column
	// replaced by the right-hand side.
	mat3_t m_main;
	mat3_t m_x;
	mat3_t m_y;
	mat3_t m_z;

	det_t d_main;
	det_t d_x;
	det_t d_y;
	det_t d_z;

	lane_res_t r_x;
	lane_res_t r_y;
	lane_res_t r_z;

	logic [LATENCY-1:0] vld_q;
	logic [DIV_LAT-1:0] sing_q;

	always_comb begin
		m_main[0] = operands.a11;
		m_main[1] = operands.a12;
		m_main[2] = operands.a13;
		m_main[3] = operands.a21;
		m_main[4] = operands.a22;
		m_main[5] = operands.a23;
		m_main[6] = operands.a31;
		m_main[7] = operands.a32;
		m_main[8] = operands.a33;

		m_x    = m_main;
		m_x[0] = operands.rhs1;
		m_x[3] = operands.rhs2;
		m_x[6] = operands.rhs3;

		m_y    = m_main;
		m_y[1] = operands.rhs1;
		m_y[4] = operands.rhs2;
		m_y[7] = operands.rhs3;

		m_z    = m_main;
		m_z[2] = operands.rhs1;
		m_z[5] = operands.rhs2;
		m_z[8] = operands.rhs3;
	end

	lss_det3 u_det_main (.clk(clk), .mat(m_main), .det(d_main));
	lss_det3 u_det_x    (.clk(clk), .mat(m_x),    .det(d_x));
	lss_det3 u_det_y    (.clk(clk), .mat(m_y),    .det(d_y));
	lss_det3 u_det_z    (.clk(clk), .mat(m_z),    .det(d_z));

	// Each unknown divides its own determinant by the main one in its own lane.
	lss_div u_div_x (.clk(clk), .num(d_x), .den(d_main), .res(r_x));
	lss_div u_div_y (.clk(clk), .num(d_y), .den(d_main), .res(r_y));
	lss_div u_div_z (.clk(clk), .num(d_z), .den(d_main), .res(r_z));

	// The singular flag rides alongside the division lanes.
	always_ff @(posedge clk) begin
		sing_q <= {sing_q[DIV_LAT-2:0], (d_main == '0)};
	end

	lss_merge u_merge (
		.clk     (clk),
		.lx      (r_x),
		.ly      (r_y),
		.lz      (r_z),
		.singular(sing_q[DIV_LAT-1]),
		.solution(solution)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LATENCY-1];

endmodule

[hw/rtl/lss_checker.sv]
// Port-level checker for the solver top level, attached by the bind below.
// Depends on lss_pkg.
module lss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input lss_pkg::solution_t solution
);
	import lss_pkg::*;

	// Every accepted transaction yields its result after the latency given by LATENCY.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction produced no result on time");

	// No result appears without a transaction accepted the latency before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching transaction");

	// A singular system reports all unknowns as zero.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && solution.status == ST_SINGULAR) |->
		(solution.sol_x == '0 && solution.sol_y == '0 && solution.sol_z == '0))
		else $error("singular result with nonzero unknowns");

	// A saturated result has at least one unknown at a range limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && solution.status == ST_SATURATED) |->
		(solution.sol_x == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
		 solution.sol_x == {1'b1, {(DATA_WIDTH-1){1'b0}}} ||
		 solution.sol_y == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
		 solution.sol_y == {1'b1, {(DATA_WIDTH-1){1'b0}}} ||
		 solution.sol_z == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
		 solution.sol_z == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
		else $error("saturated status with no unknown at a limit");

endmodule

bind linear_system_3x3_solver_top lss_checker u_lss_checker (.*);
